// ===== sv/spin_slater_exchange_defines.svh =====
// Assertion macros shared by the checker.
`ifndef SPIN_SLATER_EXCHANGE_DEFINES_SVH
`define SPIN_SLATER_EXCHANGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spin_slater_exchange check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spin_slater_exchange check failed");

// Next-cycle implication that also holds across reset.
`define SSE_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spin_slater_exchange check failed");

`endif

// ===== sv/sse_pkg.sv =====
`default_nettype none
package sse_pkg;
    localparam int DEF_DENSITY_BITS = 32;
    localparam int DEF_FRAC_BITS    = 24;
    localparam int OUT_W            = 32;
    localparam int ALPHA_W          = 16;
    localparam int COEF_W           = 31;
    localparam int AK_W             = ALPHA_W + COEF_W;
    localparam int RND_SHIFT        = 45;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [COEF_W-1:0]  COEF_POT    = 31'd1998288803;
    localparam logic [COEF_W-1:0]  COEF_EN     = 31'd1498716602;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd21845;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 1'b0,
        CFG_SPIN  = 1'b1
    } t_cfg_idx;
endpackage
`default_nettype wire

// ===== sv/sse_ifs.sv =====
`default_nettype none
interface sse_in_if #(parameter int DB = sse_pkg::DEF_DENSITY_BITS) ();
    logic          valid;
    logic          ready;
    logic [DB-1:0] density_up;
    logic [DB-1:0] density_down;
    logic          last_in;
    modport source(output valid, density_up, density_down, last_in, input ready);
    modport sink(input valid, density_up, density_down, last_in, output ready);
endinterface

interface sse_out_if ();
    import sse_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] energy_density;
    logic signed [OUT_W-1:0] potential_up;
    logic signed [OUT_W-1:0] potential_down;
    logic                    last_out;
    modport source(output valid, energy_density, potential_up, potential_down, last_out,
                   input ready);
    modport sink(input valid, energy_density, potential_up, potential_down, last_out,
                 output ready);
endinterface

interface sse_cfg_if ();
    import sse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/sse_cbrt.sv =====
`default_nettype none
module sse_cbrt #(
    parameter int ROOT_W = 27,
    parameter int DB     = 32,
    parameter int FB     = 24,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DB-1:0]     i_x_a,
    input  logic [DB-1:0]     i_x_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root_a,
    output logic [ROOT_W-1:0] o_root_b,
    output logic [SIDE_W-1:0] o_side
);
    localparam int PAD_W = 3 * ROOT_W;
    localparam int SQ_W  = 2 * ROOT_W;
    localparam int RW    = 2 * ROOT_W + 5;

    typedef struct packed {
        logic [PAD_W-1:0]  rad;
        logic [ROOT_W-1:0] y;
        logic [SQ_W-1:0]   s;
        logic [RW-1:0]     r;
    } t_lane;

    // One root bit per stage; s tracks y squared so the trial needs no multiplier.
    function automatic t_lane step(t_lane p);
        t_lane         q;
        logic [RW-1:0] r_sh;
        logic [RW-1:0] trial;
        r_sh  = RW'({p.r, p.rad[PAD_W-1 -: 3]});
        trial = RW'({p.s, 3'b000}) + RW'({p.s, 2'b00}) + RW'({p.y, 2'b00})
              + RW'({p.y, 1'b0}) + RW'(1);
        q.rad = p.rad << 3;
        if (r_sh >= trial) begin
            q.r = r_sh - trial;
            q.y = {p.y[ROOT_W-2:0], 1'b1};
            q.s = SQ_W'({p.s, 2'b00}) + SQ_W'({p.y, 2'b00}) + SQ_W'(1);
        end else begin
            q.r = r_sh;
            q.y = {p.y[ROOT_W-2:0], 1'b0};
            q.s = SQ_W'({p.s, 2'b00});
        end
        return q;
    endfunction

    t_lane             w_a_in;
    t_lane             w_b_in;
    t_lane             r_a    [ROOT_W];
    t_lane             r_b    [ROOT_W];
    logic              r_v    [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    assign w_a_in = '{rad: PAD_W'({i_x_a, {(2 * FB){1'b0}}}), y: '0, s: '0, r: '0};
    assign w_b_in = '{rad: PAD_W'({i_x_b, {(2 * FB){1'b0}}}), y: '0, s: '0, r: '0};

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
                if (i_en) begin
                    r_a[k]    <= step(w_a_in);
                    r_b[k]    <= step(w_b_in);
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
                if (i_en) begin
                    r_a[k]    <= step(r_a[k-1]);
                    r_b[k]    <= step(r_b[k-1]);
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid  = r_v[ROOT_W-1];
    assign o_root_a = r_a[ROOT_W-1].y;
    assign o_root_b = r_b[ROOT_W-1].y;
    assign o_side   = r_side[ROOT_W-1];
endmodule
`default_nettype wire

// ===== sv/sse_div.sv =====
`default_nettype none
module sse_div #(
    parameter int ROOT_W = 27,
    parameter int NUM_W  = 60,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_quot,
    output logic [SIDE_W-1:0] o_side
);
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [ROOT_W-1:0] q;
    } t_div;

    // Restoring step for quotient bit b; the quotient is known to fit ROOT_W bits.
    function automatic t_div step(t_div p, int b);
        t_div             n;
        logic [NUM_W-1:0] dsh;
        dsh   = NUM_W'(p.den) << b;
        n.den = p.den;
        if (p.rem >= dsh) begin
            n.rem = p.rem - dsh;
            n.q   = {p.q[ROOT_W-2:0], 1'b1};
        end else begin
            n.rem = p.rem;
            n.q   = {p.q[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    t_div              w_in;
    t_div              r_d    [ROOT_W];
    logic              r_v    [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    assign w_in = '{rem: i_num, den: i_den, q: '0};

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
                if (i_en) begin
                    r_d[k]    <= step(w_in, ROOT_W - 1 - k);
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
                if (i_en) begin
                    r_d[k]    <= step(r_d[k-1], ROOT_W - 1 - k);
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_quot  = r_d[ROOT_W-1].q;
    assign o_side  = r_side[ROOT_W-1];
endmodule
`default_nettype wire

// ===== sv/sse_scale.sv =====
`default_nettype none
module sse_scale #(
    parameter int ROOT_W = 27
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [sse_pkg::AK_W-1:0]         i_ak,
    input  logic [ROOT_W-1:0]                i_v,
    output logic signed [sse_pkg::OUT_W-1:0] o_res
);
    import sse_pkg::*;

    localparam int LO_W = ROOT_W / 2;
    localparam int HI_W = ROOT_W - LO_W;
    localparam int P_W  = AK_W + ROOT_W + 1;

    logic [AK_W+LO_W-1:0] r_lo;
    logic [AK_W+HI_W-1:0] r_hi;
    logic [P_W-1:0]       r_p;
    logic [P_W-1:0]       w_sh;
    logic [OUT_W-1:0]     w_mag;

    always_comb begin
        w_sh = r_p >> RND_SHIFT;
        if (w_sh > (P_W'(1) << (OUT_W - 1))) begin
            w_mag = OUT_W'(1) << (OUT_W - 1);
        end else begin
            w_mag = w_sh[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= (AK_W + LO_W)'(i_ak) * (AK_W + LO_W)'(i_v[LO_W-1:0]);
            r_hi  <= (AK_W + HI_W)'(i_ak) * (AK_W + HI_W)'(i_v[ROOT_W-1:LO_W]);
            r_p   <= P_W'(r_lo) + (P_W'(r_hi) << LO_W) + (P_W'(1) << (RND_SHIFT - 1));
            o_res <= signed'(OUT_W'(0) - w_mag);
        end
    end
endmodule
`default_nettype wire

// ===== sv/spin_slater_exchange.sv =====
// A point passes the cube-root stages, the multiply and add registers, the divider
// stages, then the scaling registers; ROOT_W is ceil((DENSITY_BITS + 2*FRAC_BITS)/3).
// Throughput: one point per cycle while not stalled; the cube root and divider retire
// one bit per stage. A stalled output freezes the whole pipeline; only then is input
// ready low. Reset is synchronous, active low: it empties the pipeline, sets alpha to
// 21845 and selects unpolarized mode.
`default_nettype none
module spin_slater_exchange #(
    parameter int DENSITY_BITS = sse_pkg::DEF_DENSITY_BITS,
    parameter int FRAC_BITS    = sse_pkg::DEF_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sse_in_if.sink     i_in,
    sse_out_if.source  o_out,
    sse_cfg_if.sink    i_cfg
);
    import sse_pkg::*;

    localparam int ROOT_W   = (DENSITY_BITS + 2 * FRAC_BITS + 2) / 3;
    localparam int NUM_W    = DENSITY_BITS + ROOT_W + 1;
    localparam int DEN_W    = DENSITY_BITS + 1;
    localparam int C_SIDE_W = 2 * DENSITY_BITS + 1;
    localparam int D_SIDE_W = 2 * ROOT_W + 2;

    logic [ALPHA_W-1:0] r_alpha;
    logic               r_pol;
    logic [AK_W-1:0]    r_ak_en;
    logic [AK_W-1:0]    r_ak_pot;
    logic               w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_pol   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ALPHA: r_alpha <= i_cfg.data;
                CFG_SPIN:  r_pol   <= i_cfg.data[0];
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_ak_en  <= AK_W'(r_alpha) * AK_W'(COEF_EN);
        r_ak_pot <= AK_W'(r_alpha) * AK_W'(COEF_POT);
    end

    logic                    r_sv [3];
    logic                    r_sl [3];
    assign w_en       = !r_sv[2] || o_out.ready;
    assign i_in.ready = w_en;

    logic                    c_valid;
    logic [ROOT_W-1:0]       c_ru;
    logic [ROOT_W-1:0]       c_rd;
    logic [C_SIDE_W-1:0]     c_side;

    sse_cbrt #(
        .ROOT_W(ROOT_W), .DB(DENSITY_BITS), .FB(FRAC_BITS), .SIDE_W(C_SIDE_W)
    ) u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_x_a   (i_in.density_up),
        .i_x_b   (i_in.density_down),
        .i_side  ({i_in.last_in, i_in.density_up, i_in.density_down}),
        .o_valid (c_valid),
        .o_root_a(c_ru),
        .o_root_b(c_rd),
        .o_side  (c_side)
    );

    logic [DENSITY_BITS-1:0] w_c_up;
    logic [DENSITY_BITS-1:0] w_c_dn;
    assign w_c_up = c_side[2*DENSITY_BITS-1:DENSITY_BITS];
    assign w_c_dn = c_side[DENSITY_BITS-1:0];

    logic               r_m_v;
    logic [NUM_W-1:0]   r_m_pu;
    logic [NUM_W-1:0]   r_m_pd;
    logic [ROOT_W-1:0]  r_m_ru;
    logic [ROOT_W-1:0]  r_m_rd;
    logic [DEN_W-1:0]   r_m_den;
    logic               r_m_last;

    logic               r_a_v;
    logic [NUM_W-1:0]   r_a_num;
    logic [ROOT_W-1:0]  r_a_ru;
    logic [ROOT_W-1:0]  r_a_rd;
    logic [DEN_W-1:0]   r_a_den;
    logic               r_a_dz;
    logic               r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= c_valid;
            r_a_v <= r_m_v;
        end
        if (w_en) begin
            r_m_pu   <= NUM_W'(w_c_up) * NUM_W'(c_ru);
            r_m_pd   <= NUM_W'(w_c_dn) * NUM_W'(c_rd);
            r_m_ru   <= c_ru;
            r_m_rd   <= c_rd;
            r_m_den  <= DEN_W'(w_c_up) + DEN_W'(w_c_dn);
            r_m_last <= c_side[C_SIDE_W-1];
            r_a_num  <= r_m_pu + r_m_pd;
            r_a_ru   <= r_m_ru;
            r_a_rd   <= r_m_rd;
            r_a_den  <= r_m_den;
            r_a_dz   <= (r_m_den == '0);
            r_a_last <= r_m_last;
        end
    end

    logic                d_valid;
    logic [ROOT_W-1:0]   d_q;
    logic [D_SIDE_W-1:0] d_side;

    sse_div #(
        .ROOT_W(ROOT_W), .NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(D_SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_a_v),
        .i_num  (r_a_num),
        .i_den  (r_a_den),
        .i_side ({r_a_last, r_a_dz, r_a_ru, r_a_rd}),
        .o_valid(d_valid),
        .o_quot (d_q),
        .o_side (d_side)
    );

    logic [ROOT_W-1:0] w_d_ru;
    logic [ROOT_W-1:0] w_d_rd;
    logic [ROOT_W-1:0] w_w;
    logic [ROOT_W-1:0] w_vdn;

    assign w_d_ru = d_side[2*ROOT_W-1:ROOT_W];
    assign w_d_rd = d_side[ROOT_W-1:0];

    always_comb begin
        if (!r_pol) begin
            w_w   = w_d_ru;
            w_vdn = w_d_ru;
        end else begin
            w_w   = d_side[2*ROOT_W] ? '0 : d_q;
            w_vdn = w_d_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
            r_sv[1] <= 1'b0;
            r_sv[2] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= d_valid;
            r_sv[1] <= r_sv[0];
            r_sv[2] <= r_sv[1];
        end
        if (w_en) begin
            r_sl[0] <= d_side[D_SIDE_W-1];
            r_sl[1] <= r_sl[0];
            r_sl[2] <= r_sl[1];
        end
    end

    sse_scale #(.ROOT_W(ROOT_W)) u_scale_en (
        .i_clk(i_clk), .i_en(w_en), .i_ak(r_ak_en), .i_v(w_w), .o_res(o_out.energy_density)
    );

    sse_scale #(.ROOT_W(ROOT_W)) u_scale_up (
        .i_clk(i_clk), .i_en(w_en), .i_ak(r_ak_pot), .i_v(w_d_ru), .o_res(o_out.potential_up)
    );

    sse_scale #(.ROOT_W(ROOT_W)) u_scale_dn (
        .i_clk(i_clk), .i_en(w_en), .i_ak(r_ak_pot), .i_v(w_vdn), .o_res(o_out.potential_down)
    );

    assign o_out.valid    = r_sv[2];
    assign o_out.last_out = r_sl[2];
endmodule
`default_nettype wire

// ===== sv/sse_checker.sv =====
`default_nettype none
`include "spin_slater_exchange_defines.svh"
module sse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_energy,
    input wire logic [31:0] i_pot_up,
    input wire logic [31:0] i_pot_dn,
    input wire logic        i_last
);
    logic        w_stall;
    logic [96:0] w_word;
    logic        w_nonpos;

    assign w_stall  = i_out_valid && !i_out_ready;
    assign w_word   = {i_energy, i_pot_up, i_pot_dn, i_last};
    assign w_nonpos = (i_energy[31] || i_energy == 32'd0)
                   && (i_pot_up[31] || i_pot_up == 32'd0)
                   && (i_pot_dn[31] || i_pot_dn == 32'd0);

    `SSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid)
    `SSE_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(w_word))
    `SSE_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
    `SSE_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `SSE_ASSERT_IMP(a_nonpositive, i_clk, i_rst_n, i_out_valid, w_nonpos)
endmodule

bind spin_slater_exchange sse_checker u_sse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_energy   (o_out.energy_density),
    .i_pot_up   (o_out.potential_up),
    .i_pot_dn   (o_out.potential_down),
    .i_last     (o_out.last_out)
);
`default_nettype wire

// ===== verif/tb_spin_slater_exchange.sv =====
`default_nettype none
module tb_spin_slater_exchange;
    timeunit 1ns;
    timeprecision 1ps;
    import sse_pkg::*;

    localparam int  DB         = DEF_DENSITY_BITS;
    localparam int  FB         = DEF_FRAC_BITS;
    localparam int  DRAIN      = 80;
    localparam longint LIMIT   = 400000;

    typedef struct packed {
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] pot_up;
        logic [OUT_W-1:0] pot_down;
        logic             last;
    } t_exch;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sse_in_if #(.DB(DB)) in_if ();
    sse_out_if           out_if ();
    sse_cfg_if           cfg_if ();

    spin_slater_exchange #(.DENSITY_BITS(DB), .FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    logic [ALPHA_W-1:0] alpha_q = ALPHA_RESET;
    logic               polarized_q = 1'b0;
    t_exch              expected_q[$];
    int                 errors = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_cycles = 0;
    longint             cycles = 0;

    function automatic logic [63:0] fixed_cbrt(logic [DB-1:0] x);
        logic [127:0] rad;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        rad = {96'd0, x} << (2 * FB);
        lo = 0;
        hi = 128'd1 << 28;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (mid * mid * mid <= rad) lo = mid;
            else hi = mid;
        end
        return lo[63:0];
    endfunction

    function automatic logic [OUT_W-1:0] scaled_neg(logic [COEF_W-1:0] k, logic [63:0] v);
        logic [127:0] p;
        logic [127:0] mag;
        p = {112'd0, alpha_q} * {97'd0, k} * {64'd0, v} + (128'd1 << 44);
        mag = p >> RND_SHIFT;
        if (mag > (128'd1 << 31)) mag = 128'd1 << 31;
        return OUT_W'(-mag[OUT_W-1:0]);
    endfunction

    function automatic t_exch exchange_of(logic [DB-1:0] u, logic [DB-1:0] d, logic l);
        t_exch r;
        logic [63:0]  ru;
        logic [63:0]  rd;
        logic [127:0] tot;
        logic [127:0] w;
        ru = fixed_cbrt(u);
        r.last = l;
        if (!polarized_q) begin
            r.energy = scaled_neg(COEF_EN, ru);
            r.pot_up = scaled_neg(COEF_POT, ru);
            r.pot_down = r.pot_up;
        end else begin
            tot = {96'd0, u} + {96'd0, d};
            if (tot == 0) begin
                r.energy = 0;
                r.pot_up = 0;
                r.pot_down = 0;
            end else begin
                rd = fixed_cbrt(d);
                w = ({96'd0, u} * {64'd0, ru} + {96'd0, d} * {64'd0, rd}) / tot;
                r.energy = scaled_neg(COEF_EN, w[63:0]);
                r.pot_up = scaled_neg(COEF_POT, ru);
                r.pot_down = scaled_neg(COEF_POT, rd);
            end
        end
        return r;
    endfunction

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_if.ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_exch got;
        t_exch want;
        if (i_rst_n && in_if.valid && in_if.ready)
            expected_q.push_back(exchange_of(in_if.density_up, in_if.density_down,
                                             in_if.last_in));
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.energy_density, out_if.potential_up, out_if.potential_down,
                   out_if.last_out};
            if (expected_q.size() == 0) begin
                report("unexpected beat", got.energy, 'x);
            end else begin
                want = expected_q.pop_front();
                if (got.energy !== want.energy) report("energy_density", got.energy, want.energy);
                if (got.pot_up !== want.pot_up) report("potential_up", got.pot_up, want.pot_up);
                if (got.pot_down !== want.pot_down)
                    report("potential_down", got.pot_down, want.pot_down);
                if (got.last !== want.last) report("last_out", got.last, want.last);
            end
        end
    end

    task automatic send_point(logic [DB-1:0] u, logic [DB-1:0] d, logic l);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.density_up <= u;
        in_if.density_down <= d;
        in_if.last_in <= l;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        stop_sending();
        wait (expected_q.size() == 0);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_ALPHA) alpha_q = value;
        else polarized_q = value[0];
        @(posedge i_clk);
    endtask

    function automatic logic [DB-1:0] rand_density();
        case ($urandom_range(5))
            0: return '0;
            1: return DB'($urandom_range(255));
            2: return DB'($urandom_range(32'h0100_0000));
            default: return DB'($urandom);
        endcase
    endfunction

    task automatic test_unpolarized_edges();
        write_reg(CFG_SPIN, 16'd0);
        send_point('0, '1, 1'b0);
        send_point(32'd1, '0, 1'b1);
        send_point('1, 32'h1234_5678, 1'b0);
        send_point(32'h0100_0000, '0, 1'b0);
        send_point(32'h8000_0000, '1, 1'b1);
    endtask

    task automatic test_polarized_edges();
        write_reg(CFG_SPIN, 16'd1);
        send_point('0, '0, 1'b0);
        send_point('0, 32'h0100_0000, 1'b0);
        send_point(32'h0100_0000, '0, 1'b1);
        send_point('1, '1, 1'b0);
        send_point(32'd1, '1, 1'b0);
        send_point('1, 32'd1, 1'b1);
        send_point(32'h0100_0000, 32'h0100_0000, 1'b0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    endtask

    task automatic test_alpha_extremes();
        write_reg(CFG_ALPHA, 16'd0);
        send_point('1, '1, 1'b0);
        send_point(32'h0100_0000, '0, 1'b1);
        write_reg(CFG_ALPHA, 16'hFFFF);
        send_point('1, '1, 1'b0);
        send_point('1, '0, 1'b1);
        write_reg(CFG_SPIN, 16'd0);
        send_point('1, '0, 1'b0);
        send_point(32'd1, '0, 1'b1);
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(CFG_ALPHA, ($urandom_range(3) == 0) ? 16'(ALPHA_RESET) : 16'($urandom));
        write_reg(CFG_SPIN, 16'($urandom_range(1)));
        repeat (n) send_point(rand_density(), rand_density(), 1'($urandom_range(1)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_SPIN, 16'd1);
        hold_cycles = 300;
        repeat (100) send_point(rand_density(), rand_density(), 1'($urandom_range(1)));
    endtask

    initial begin
        in_if.valid <= 1'b0;
        in_if.density_up <= '0;
        in_if.density_down <= '0;
        in_if.last_in <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_ALPHA;
        cfg_if.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unpolarized_edges();
        test_polarized_edges();
        test_alpha_extremes();
        test_random(60, 0, 0);
        test_random(60, 67, 0);
        test_random(60, 0, 67);
        test_random(60, 32, 32);
        test_backpressure();
        test_random(50, 0, 0);
        test_random(60, 32, 32);

        stop_sending();
        wait (expected_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/sse_pkg.sv
sv/sse_ifs.sv
sv/sse_cbrt.sv
sv/sse_div.sv
sv/sse_scale.sv
sv/spin_slater_exchange.sv
sv/sse_checker.sv
verif/tb_spin_slater_exchange.sv
